// ===== rtl/mdt_pkg.sv =====
// Shared types and constants for the Manhattan distance transform block.
// Holds the item and result payloads and the controller/datapath interface.
// Depends on nothing.
`default_nettype none

package mdt_pkg;

  // Default store dimensions, handed to the top level as parameter defaults.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int DIST_W = 7;
  localparam int CFG_W  = 7;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_COMPUTE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_bit;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              none_found;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read;
    logic fwd_init;
    logic fwd_wr;
    logic bwd_init;
    logic bwd_rd;
    logic bwd_wr;
  } cmd_t;

  // Scan position status from the datapath to the controller.
  typedef struct packed {
    logic col_end;
    logic row_end;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/mdt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the grid, forward-pass and distance stores. No dependencies.
`default_nettype none

module mdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mdt_ctrl.sv =====
// Controller state machine: decodes accepted items and sequences the two
// raster passes of a compute. Depends on mdt_pkg.
`default_nettype none

module mdt_ctrl
  import mdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] kind,
  input  wire status_t    status,
  output logic            busy,
  output cmd_t            cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRD   = 3'd1;
  localparam logic [2:0] S_FWR   = 3'd2;
  localparam logic [2:0] S_BINIT = 3'd3;
  localparam logic [2:0] S_BRD   = 3'd4;
  localparam logic [2:0] S_BWR   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load     = accept && (kind == KIND_LOAD);
        cmd.read     = accept && (kind == KIND_READ);
        cmd.fwd_init = accept && (kind == KIND_COMPUTE);
        if (cmd.fwd_init) begin
          state_next = S_FRD;
        end
      end
      S_FRD: begin
        state_next = S_FWR;
      end
      S_FWR: begin
        cmd.fwd_wr = 1'b1;
        state_next = (status.col_end && status.row_end) ? S_BINIT : S_FRD;
      end
      S_BINIT: begin
        cmd.bwd_init = 1'b1;
        state_next   = S_BRD;
      end
      S_BRD: begin
        cmd.bwd_rd = 1'b1;
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.bwd_wr = 1'b1;
        state_next = (status.col_end && status.row_end) ? S_IDLE : S_BRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mdt_datapath.sv =====
// Datapath: configuration registers, scan counters, the three stores and
// the per-cell min logic of both raster passes, plus the read result stage.
// Depends on mdt_pkg and mdt_ram.
`default_nettype none

module mdt_datapath
  import mdt_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire item_t            item,
  input  wire cmd_t             cmd,
  output status_t               status,
  output result_t               result,
  output logic                  result_valid
);

  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NRW     = $clog2(MAX_ROWS + 1);
  localparam int NCW     = $clog2(MAX_COLS + 1);
  localparam int FAR_VAL = MAX_ROWS + MAX_COLS + 2;
  localparam int FW      = $clog2(FAR_VAL + 1);
  localparam int EW      = (FW + 1 > DIST_W + 1) ? FW + 1 : DIST_W + 1;
  localparam int XW      = 9 + NCW + 1;

  localparam logic [EW-1:0]     FAR_E    = EW'(FAR_VAL);
  localparam logic [EW-1:0]     DIST_SAT = EW'((1 << DIST_W) - 1);
  localparam logic [XW-1:0]     COLS_X   = XW'(MAX_COLS);

  function automatic logic [AW-1:0] addr_of(logic [8:0] rr, logic [8:0] cc);
    logic [XW-1:0] p;
    p = XW'(rr) * COLS_X + XW'(cc);
    return p[AW-1:0];
  endfunction

  // Zero counts as one; anything above the store size uses the store size.
  function automatic logic [8:0] clamp_dim(logic [CFG_W-1:0] v, logic [8:0] lim);
    logic [8:0] ve;
    ve = {2'b00, v};
    if (ve == 9'd0) begin
      return 9'd1;
    end else if (ve > lim) begin
      return lim;
    end
    return ve;
  endfunction

  function automatic logic [EW-1:0] min_e(logic [EW-1:0] a, logic [EW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [CFG_W-1:0]  grid_rows;
  logic [CFG_W-1:0]  grid_cols;
  logic [NRW-1:0]    nr;
  logic [NCW-1:0]    nc;

  logic [RW-1:0]     r;
  logic [CW-1:0]     c;
  logic              bwd_pass;
  logic              seen;
  logic              any_one_seen;
  logic [FW-1:0]     left;
  logic [FW-1:0]     right;

  logic              rd_pend;
  logic              rd_in_region;

  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     up_addr;
  logic [AW-1:0]     down_addr;
  logic [AW-1:0]     item_addr;
  logic              in_store;
  logic              in_region;

  logic              grid_rdata;
  logic [FW-1:0]     fwd_rdata;
  logic [DIST_W-1:0] dist_rdata;
  logic [AW-1:0]     fwd_raddr;
  logic [AW-1:0]     dist_raddr;

  logic [EW-1:0]     fwd_d;
  logic [EW-1:0]     bwd_d;
  logic [DIST_W-1:0] dist_wdata;

  assign nr = NRW'(clamp_dim(grid_rows, 9'(MAX_ROWS)));
  assign nc = NCW'(clamp_dim(grid_cols, 9'(MAX_COLS)));

  assign cell_addr = addr_of(9'(r), 9'(c));
  assign up_addr   = addr_of(9'(r) - 9'd1, 9'(c));
  assign down_addr = addr_of(9'(r) + 9'd1, 9'(c));
  assign item_addr = addr_of({3'b000, item.row}, {3'b000, item.col});

  assign in_store  = ({3'b000, item.row} < 9'(MAX_ROWS)) &&
                     ({3'b000, item.col} < 9'(MAX_COLS));
  assign in_region = ({3'b000, item.row} < 9'(nr)) && ({3'b000, item.col} < 9'(nc));

  // The forward pass scans right and down, the backward pass left and up.
  assign status.col_end = bwd_pass ? (c == '0) : (NCW'(c) + NCW'(1) == nc);
  assign status.row_end = bwd_pass ? (r == '0) : (NRW'(r) + NRW'(1) == nr);

  assign fwd_raddr  = cmd.bwd_rd ? cell_addr : up_addr;
  assign dist_raddr = cmd.read ? item_addr : down_addr;

  always_comb begin
    fwd_d = FAR_E;
    if (r != '0) begin
      fwd_d = min_e(fwd_d, EW'(fwd_rdata) + EW'(1));
    end
    if (c != '0) begin
      fwd_d = min_e(fwd_d, EW'(left) + EW'(1));
    end
    if (grid_rdata) begin
      fwd_d = '0;
    end
  end

  always_comb begin
    bwd_d = EW'(fwd_rdata);
    if (NRW'(r) + NRW'(1) < nr) begin
      bwd_d = min_e(bwd_d, EW'(dist_rdata) + EW'(1));
    end
    if (NCW'(c) + NCW'(1) < nc) begin
      bwd_d = min_e(bwd_d, EW'(right) + EW'(1));
    end
    if (!any_one_seen) begin
      dist_wdata = '0;
    end else if (bwd_d > DIST_SAT) begin
      dist_wdata = DIST_SAT[DIST_W-1:0];
    end else begin
      dist_wdata = bwd_d[DIST_W-1:0];
    end
  end

  mdt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid_ram (
    .clk   (clk),
    .we    (cmd.load && in_store),
    .waddr (item_addr),
    .wdata (item.cell_bit),
    .raddr (cell_addr),
    .rdata (grid_rdata)
  );

  mdt_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_fwd_ram (
    .clk   (clk),
    .we    (cmd.fwd_wr),
    .waddr (cell_addr),
    .wdata (fwd_d[FW-1:0]),
    .raddr (fwd_raddr),
    .rdata (fwd_rdata)
  );

  mdt_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist_ram (
    .clk   (clk),
    .we    (cmd.bwd_wr),
    .waddr (cell_addr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_DIM_RESET;
      grid_cols <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) begin
        grid_rows <= cfg_data;
      end
      if (cfg_index == CFG_COLS) begin
        grid_cols <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r            <= '0;
      c            <= '0;
      bwd_pass     <= 1'b0;
      seen         <= 1'b0;
      any_one_seen <= 1'b0;
    end else if (cmd.fwd_init) begin
      r        <= '0;
      c        <= '0;
      bwd_pass <= 1'b0;
      seen     <= 1'b0;
    end else if (cmd.fwd_wr) begin
      seen <= seen | grid_rdata;
      if (status.col_end) begin
        c <= '0;
        r <= r + RW'(1);
      end else begin
        c <= c + CW'(1);
      end
    end else if (cmd.bwd_init) begin
      r            <= RW'(nr - NRW'(1));
      c            <= CW'(nc - NCW'(1));
      bwd_pass     <= 1'b1;
      any_one_seen <= seen;
    end else if (cmd.bwd_wr) begin
      if (status.col_end) begin
        c <= CW'(nc - NCW'(1));
        r <= r - RW'(1);
      end else begin
        c <= c - CW'(1);
      end
    end
  end

  // Neighbor values carried from the previous cell of the scan.
  always_ff @(posedge clk) begin
    if (cmd.fwd_wr) begin
      left <= fwd_d[FW-1:0];
    end
    if (cmd.bwd_wr) begin
      right <= bwd_d[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_pend      <= cmd.read;
      result_valid <= rd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_in_region <= in_region;
    end
    result.distance   <= rd_in_region ? dist_rdata : '0;
    result.none_found <= !any_one_seen;
  end

endmodule

`default_nettype wire

// ===== rtl/manhattan_distance_transform.sv =====
// Top level of the 4-neighbour Manhattan distance transform block.
// Joins the controller and the datapath. Depends on mdt_pkg, mdt_ctrl,
// mdt_datapath and mdt_ram.
//
//   Channel   Ports                             Transaction
//   item      start, busy, item                 start high while busy low
//   result    result_valid, result              result_valid high, one cycle
//   config    cfg_we, cfg_index, cfg_data       cfg_we high
//
// A load or a read leaves busy low; a new item may follow on the next edge.
// A read result passes the store read and result registers and is shown for one cycle.
// A compute holds busy through both passes: each pass takes every cell through a
// read state for the registered store reads and then a write state for the update.
// Reset sets both dimensions to 64 and marks the grid as holding no target
// cell; the stores are not cleared. The receiver cannot stall results.
`default_nettype none

module manhattan_distance_transform
  import mdt_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire item_t            item,
  output logic                  result_valid,
  output result_t               result,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  mdt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (item.kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  mdt_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire
